>>> src/tkp_pkg.sv
// ----------------------------------------------------------------------------
// tkp_pkg: shared types and constants of the top-K positive cell selector
// Field widths, list sizing, register map and controller/datapath structs.
// ----------------------------------------------------------------------------
`default_nettype none

package tkp_pkg;

  localparam int MAX_KEEP    = 16;
  localparam int GRID_SIDE   = 64;
  localparam int LAYER_COUNT = 16;

  localparam int SCORE_W = 32;
  localparam int COORD_W = $clog2(GRID_SIDE);
  localparam int LAYER_W = $clog2(LAYER_COUNT);
  localparam int IDX_W   = $clog2(MAX_KEEP);
  localparam int COUNT_W = $clog2(MAX_KEEP + 1);

  // APB register map
  localparam int PDATA_W = 32;
  localparam int PADDR_W = 3;
  localparam logic REG_REPORT_COUNT = 1'b0;
  localparam int   REPORT_COUNT_W   = 5;
  localparam logic [REPORT_COUNT_W-1:0] REPORT_COUNT_RST = 5'd10;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [COORD_W-1:0]        col;
    logic [COORD_W-1:0]        row;
    logic [LAYER_W-1:0]        layer;
  } entry_t;

  typedef struct packed {
    logic ins;    // a cell beat is taken this cycle
    logic pop;    // head was delivered, shift list up
    logic clear;  // run done, empty the list
  } dp_cmd_t;

  typedef struct packed {
    logic [COUNT_W-1:0] kept;
  } dp_status_t;

endpackage

`default_nettype wire

>>> src/tkp_in_if.sv
// ----------------------------------------------------------------------------
// tkp_in_if: cell input channel
// Valid/ready channel carrying one grid cell per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface tkp_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [tkp_pkg::SCORE_W-1:0]  cell_score;
  logic [tkp_pkg::COORD_W-1:0]         col_index;
  logic [tkp_pkg::COORD_W-1:0]         row_index;
  logic [tkp_pkg::LAYER_W-1:0]         layer_index;
  logic                                frame_end;

  modport source (output valid, cell_score, col_index, row_index, layer_index, frame_end,
                  input ready);
  modport sink   (input valid, cell_score, col_index, row_index, layer_index, frame_end,
                  output ready);
endinterface

`default_nettype wire

>>> src/tkp_out_if.sv
// ----------------------------------------------------------------------------
// tkp_out_if: ranked result channel
// Valid/ready channel carrying one reported cell per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface tkp_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [tkp_pkg::SCORE_W-1:0]  best_score;
  logic [tkp_pkg::COORD_W-1:0]         best_col;
  logic [tkp_pkg::COORD_W-1:0]         best_row;
  logic [tkp_pkg::LAYER_W-1:0]         best_layer;
  logic [tkp_pkg::IDX_W-1:0]           rank;
  logic                                none_found;
  logic                                run_end;

  modport source (output valid, best_score, best_col, best_row, best_layer, rank,
                  none_found, run_end, input ready);
  modport sink   (input valid, best_score, best_col, best_row, best_layer, rank,
                  none_found, run_end, output ready);
endinterface

`default_nettype wire

>>> src/top_k_positive_cell_selector_unit.sv
// ----------------------------------------------------------------------------
// top_k_positive_cell_selector_unit: top-K positive cell selector
// Keeps the best positive-score cells of a frame and reports them ranked.
// ----------------------------------------------------------------------------
// The frame_end beat moves the controller to S_LOAD, then to S_EMIT, where the
//   first result beat is valid. Throughput: one cell beat per cycle while a frame
//   fills; insertion is a parallel compare and shift across the 16-entry list.
// A frame's report has a setup state, S_LOAD, then min(report count, kept) result
//   beats in S_EMIT, or one beat if empty; no cell is taken meanwhile.
// Reset (rst, synchronous): list empty, report count = 10, controller in fill.
`default_nettype none

module top_k_positive_cell_selector_unit (
  input  wire                              clk,
  input  wire                              rst,
  tkp_in_if.sink                           in_ch,
  tkp_out_if.source                        out_ch,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire [tkp_pkg::PADDR_W-1:0]       paddr,
  input  wire [tkp_pkg::PDATA_W-1:0]       pwdata,
  output logic [tkp_pkg::PDATA_W-1:0]      prdata,
  output logic                             pready
);

  logic [tkp_pkg::REPORT_COUNT_W-1:0] report_count;
  logic                            reg_hit;
  tkp_pkg::dp_cmd_t                cmd;
  tkp_pkg::dp_status_t             status;
  tkp_pkg::entry_t                 new_entry;
  tkp_pkg::entry_t                 head;
  logic [tkp_pkg::IDX_W-1:0]       rank;
  logic                            none;
  logic                            run_last;

  // ---- APB register: word index taken from paddr above the byte offset ----
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == tkp_pkg::REG_REPORT_COUNT);
  assign prdata  = reg_hit ? tkp_pkg::PDATA_W'(report_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      report_count <= tkp_pkg::REPORT_COUNT_RST;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      report_count <= pwdata[tkp_pkg::REPORT_COUNT_W-1:0];
    end
  end

  // ---- cell beat into the list ----
  assign new_entry.score = in_ch.cell_score;
  assign new_entry.col   = in_ch.col_index;
  assign new_entry.row   = in_ch.row_index;
  assign new_entry.layer = in_ch.layer_index;

  tkp_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_ch.valid),
    .in_frame_end (in_ch.frame_end),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .report_count (report_count),
    .status       (status),
    .cmd          (cmd),
    .rank         (rank),
    .none         (none),
    .run_last     (run_last)
  );

  tkp_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .new_entry (new_entry),
    .status    (status),
    .head      (head)
  );

  // ---- result beat: list head is the output register; empty run shows zeros ----
  assign out_ch.best_score = none ? '0 : head.score;
  assign out_ch.best_col   = none ? '0 : head.col;
  assign out_ch.best_row   = none ? '0 : head.row;
  assign out_ch.best_layer = none ? '0 : head.layer;
  assign out_ch.rank       = rank;
  assign out_ch.none_found = none;
  assign out_ch.run_end    = run_last;

`ifndef SYNTH
  // list is empty once a run's last beat is taken
  a_clear_after_run: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && out_ch.run_end) |=> (status.kept == '0))
    else $error("list not cleared after run");

  // an empty report is a single beat
  a_none_single: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.none_found) |-> (out_ch.run_end && out_ch.rank == '0))
    else $error("empty report not a single beat");

  // no cell taken while reporting
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ch.ready && out_ch.valid))
    else $error("input open during report");

  // frame end closes the input
  a_frame_close: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready && in_ch.frame_end) |=> !in_ch.ready)
    else $error("input still open after frame end");

  // kept count never exceeds list depth
  a_kept_bound: assert property (@(posedge clk) disable iff (rst)
    status.kept <= tkp_pkg::COUNT_W'(tkp_pkg::MAX_KEEP))
    else $error("kept count overflow");
`endif

endmodule

`default_nettype wire

>>> src/tkp_datapath.sv
// ----------------------------------------------------------------------------
// tkp_datapath: sorted insertion list
// Compare-and-shift list of MAX_KEEP entries, descending score, stable on ties.
// ----------------------------------------------------------------------------
`default_nettype none

module tkp_datapath (
  input  wire                                clk,
  input  wire                                rst,
  input  wire tkp_pkg::dp_cmd_t              cmd,
  input  wire tkp_pkg::entry_t               new_entry,
  output tkp_pkg::dp_status_t                status,
  output tkp_pkg::entry_t                    head
);

  tkp_pkg::entry_t            list      [tkp_pkg::MAX_KEEP];
  tkp_pkg::entry_t            list_next [tkp_pkg::MAX_KEEP];
  logic [tkp_pkg::COUNT_W-1:0] kept;
  logic [tkp_pkg::COUNT_W-1:0] kept_next;
  logic [tkp_pkg::MAX_KEEP-1:0] ge;   // entry ranks ahead of new cell
  logic                        fit;

  // ge is a prefix mask since the list is sorted
  always_comb begin
    for (int i = 0; i < tkp_pkg::MAX_KEEP; i++) begin
      ge[i] = (tkp_pkg::COUNT_W'(i) < kept) && (list[i].score >= new_entry.score);
    end
  end

  assign fit = (new_entry.score > 0) && !ge[tkp_pkg::MAX_KEEP-1];

  for (genvar g = 0; g < tkp_pkg::MAX_KEEP; g++) begin : g_lane
    always_comb begin
      list_next[g] = list[g];
      if (cmd.pop) begin
        if (g < tkp_pkg::MAX_KEEP - 1) begin
          list_next[g] = list[(g < tkp_pkg::MAX_KEEP - 1) ? g + 1 : g];
        end
      end else if (cmd.ins && fit && !ge[g]) begin
        if (g == 0) begin
          list_next[g] = new_entry;
        end else if (ge[(g > 0) ? g - 1 : 0]) begin
          list_next[g] = new_entry;
        end else begin
          list_next[g] = list[(g > 0) ? g - 1 : 0];
        end
      end
    end

    always_ff @(posedge clk) begin
      list[g] <= list_next[g];
    end
  end

  always_comb begin
    kept_next = kept;
    if (cmd.clear) begin
      kept_next = '0;
    end else if (cmd.ins && fit && (kept < tkp_pkg::COUNT_W'(tkp_pkg::MAX_KEEP))) begin
      kept_next = kept + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kept <= '0;
    end else begin
      kept <= kept_next;
    end
  end

  assign status.kept = kept;
  assign head        = list[0];

endmodule

`default_nettype wire

>>> src/tkp_ctrl.sv
// ----------------------------------------------------------------------------
// tkp_ctrl: frame controller
// Sequences fill, run setup and result delivery; keeps rank and run length.
// ----------------------------------------------------------------------------
`default_nettype none

module tkp_ctrl (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 in_valid,
  input  wire                                 in_frame_end,
  output logic                                in_ready,
  output logic                                out_valid,
  input  wire                                 out_ready,
  input  wire [tkp_pkg::REPORT_COUNT_W-1:0]   report_count,
  input  wire tkp_pkg::dp_status_t            status,
  output tkp_pkg::dp_cmd_t                    cmd,
  output logic [tkp_pkg::IDX_W-1:0]           rank,
  output logic                                none,
  output logic                                run_last
);

  localparam logic [1:0] S_FILL = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]                  state;
  logic [1:0]                  state_next;
  logic [tkp_pkg::COUNT_W-1:0] total;
  logic [tkp_pkg::COUNT_W-1:0] want;
  logic [tkp_pkg::COUNT_W-1:0] run_len;
  logic                        take_in;
  logic                        take_out;

  // report_count clamped to 1..MAX_KEEP
  always_comb begin
    if (report_count == '0) begin
      want = tkp_pkg::COUNT_W'(1);
    end else if (tkp_pkg::COUNT_W'(report_count) > tkp_pkg::COUNT_W'(tkp_pkg::MAX_KEEP)) begin
      want = tkp_pkg::COUNT_W'(tkp_pkg::MAX_KEEP);
    end else begin
      want = tkp_pkg::COUNT_W'(report_count);
    end
  end

  always_comb begin
    if (status.kept == '0) begin
      run_len = tkp_pkg::COUNT_W'(1);
    end else if (want < status.kept) begin
      run_len = want;
    end else begin
      run_len = status.kept;
    end
  end

  assign in_ready  = (state == S_FILL);
  assign out_valid = (state == S_EMIT);
  assign take_in   = in_valid && in_ready;
  assign take_out  = out_valid && out_ready;
  assign run_last  = ({1'b0, rank} + 1'b1) == total;

  assign cmd.ins   = take_in;
  assign cmd.pop   = take_out && !run_last;
  assign cmd.clear = take_out && run_last;

  always_comb begin
    state_next = state;
    case (state)
      S_FILL: begin
        if (take_in && in_frame_end) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: state_next = S_EMIT;
      S_EMIT: begin
        if (take_out && run_last) begin
          state_next = S_FILL;
        end
      end
      default: state_next = S_FILL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_FILL;
      rank  <= '0;
      total <= tkp_pkg::COUNT_W'(1);
      none  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_LOAD) begin
        rank  <= '0;
        total <= run_len;
        none  <= (status.kept == '0);
      end else if (take_out) begin
        rank <= rank + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> verif/tkp_tb_pkg.sv
// ----------------------------------------------------------------------------
// tkp_tb_pkg: ranking predictor and result board for the cell selector bench
// Keeps a bounded, score-sorted copy of the kept cells. On each frame end it
// queues the ranked beats that the block should report, then checks them.
// ----------------------------------------------------------------------------
package tkp_tb_pkg;

  typedef struct packed {
    logic signed [tkp_pkg::SCORE_W-1:0] score;
    logic [tkp_pkg::COORD_W-1:0]        col;
    logic [tkp_pkg::COORD_W-1:0]        row;
    logic [tkp_pkg::LAYER_W-1:0]        layer;
    logic                               frame_end;
  } cell_t;

  typedef struct packed {
    logic signed [tkp_pkg::SCORE_W-1:0] score;
    logic [tkp_pkg::COORD_W-1:0]        col;
    logic [tkp_pkg::COORD_W-1:0]        row;
    logic [tkp_pkg::LAYER_W-1:0]        layer;
    logic [tkp_pkg::IDX_W-1:0]          rank;
    logic                               none_found;
    logic                               run_end;
  } ranked_beat_t;

  class tkp_rank_board;
    cell_t                                  kept[tkp_pkg::MAX_KEEP];
    int                                     kept_n;
    logic [tkp_pkg::REPORT_COUNT_W-1:0]     report_count;
    ranked_beat_t                           due[$];
    int                                     errors;
    int                                     cells;
    int                                     frames;
    int                                     beats;

    function new();
      kept_n       = 0;
      report_count = tkp_pkg::REPORT_COUNT_RST;
      errors       = 0;
      cells        = 0;
      frames       = 0;
      beats        = 0;
    endfunction

    function void report(string msg);
      $display("%0t ERROR: %s", $time, msg);
      errors++;
    endfunction

    // Sorted insert: ties go behind equal scores, a full list drops its tail.
    function void keep_cell(cell_t c);
      int pos;
      int i;
      pos = 0;
      while (pos < kept_n && $signed(kept[pos].score) >= $signed(c.score)) pos++;
      if (pos >= tkp_pkg::MAX_KEEP) return;
      i = (kept_n < tkp_pkg::MAX_KEEP) ? kept_n : tkp_pkg::MAX_KEEP - 1;
      while (i > pos) begin
        kept[i] = kept[i-1];
        i--;
      end
      kept[pos] = c;
      if (kept_n < tkp_pkg::MAX_KEEP) kept_n++;
    endfunction

    // Accepted input beat: update the list, queue the ranked run on frame end.
    function void note_cell(cell_t c);
      ranked_beat_t b;
      int want;
      int n;
      cells++;
      if ($signed(c.score) > 0) keep_cell(c);
      if (!c.frame_end) return;
      frames++;
      if (kept_n == 0) begin
        b = '0;
        b.none_found = 1'b1;
        b.run_end    = 1'b1;
        due = {due, b};
        return;
      end
      want = (report_count == 0) ? 1 : int'(report_count);
      if (want > tkp_pkg::MAX_KEEP) want = tkp_pkg::MAX_KEEP;
      n = (want < kept_n) ? want : kept_n;
      for (int k = 0; k < n; k++) begin
        b.score      = kept[k].score;
        b.col        = kept[k].col;
        b.row        = kept[k].row;
        b.layer      = kept[k].layer;
        b.rank       = k[tkp_pkg::IDX_W-1:0];
        b.none_found = 1'b0;
        b.run_end    = (k + 1 == n);
        due = {due, b};
      end
      kept_n = 0;
    endfunction

    function void cmp_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
        report($sformatf("beat %0d: %s got 0x%0h, expected 0x%0h", beats, name, got, want));
    endfunction

    // Accepted output beat: compare against the oldest queued expectation.
    function void check_beat(ranked_beat_t got);
      ranked_beat_t want;
      if (due.size() == 0) begin
        report($sformatf("unexpected result beat, score 0x%0h rank %0d",
                         got.score, got.rank));
        return;
      end
      want = due.pop_front();
      cmp_field("best_score", 64'(got.score),      64'(want.score));
      cmp_field("best_col",   64'(got.col),        64'(want.col));
      cmp_field("best_row",   64'(got.row),        64'(want.row));
      cmp_field("best_layer", 64'(got.layer),      64'(want.layer));
      cmp_field("rank",       64'(got.rank),       64'(want.rank));
      cmp_field("none_found", 64'(got.none_found), 64'(want.none_found));
      cmp_field("run_end",    64'(got.run_end),    64'(want.run_end));
      beats++;
    endfunction
  endclass

endpackage

>>> verif/tb_top_k_positive_cell_selector_unit.sv
// ----------------------------------------------------------------------------
// tb_top_k_positive_cell_selector_unit: self-checking bench of the selector
// Streams frames of cells, predicts each ranked report and checks every beat
// field by field; sweeps the report count over APB with random idling.
// ----------------------------------------------------------------------------
module tb_top_k_positive_cell_selector_unit;

  localparam int SETTLE_CYCLES = 6;       // idle margin once every queued beat is taken
  localparam int PHASE_CELLS   = 40;      // minimum random cells per report count setting
  localparam int RUN_LIMIT     = 400000;  // time units

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [tkp_pkg::PADDR_W-1:0]  paddr = '0;
  logic [tkp_pkg::PDATA_W-1:0]  pwdata = '0;
  logic [tkp_pkg::PDATA_W-1:0]  prdata;
  logic                         pready;
  bit                           quiet = 1'b0;      // no idling on either side

  tkp_in_if  in_ch();
  tkp_out_if out_ch();

  tkp_tb_pkg::tkp_rank_board board;

  top_k_positive_cell_selector_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  // Channel inputs known from time zero.
  initial begin
    board              = new();
    in_ch.valid        = 1'b0;
    in_ch.cell_score   = '0;
    in_ch.col_index    = '0;
    in_ch.row_index    = '0;
    in_ch.layer_index  = '0;
    in_ch.frame_end    = 1'b0;
    out_ch.ready       = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Result sink: ready drops in random stall bursts, never while quiet. Beats are
  // sampled on the edge, using pre-edge values.
  // ---------------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk) begin
    if (rst || quiet) begin
      out_ch.ready <= !rst;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(1, 12) - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    tkp_tb_pkg::ranked_beat_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.score      = out_ch.best_score;
      got.col        = out_ch.best_col;
      got.row        = out_ch.best_row;
      got.layer      = out_ch.best_layer;
      got.rank       = out_ch.rank;
      got.none_found = out_ch.none_found;
      got.run_end    = out_ch.run_end;
      board.check_beat(got);
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers. Every task is entered just after a rising edge.
  // ---------------------------------------------------------------------------

  // One cell beat; an optional idle burst comes first. valid stays high
  // between back-to-back beats.
  task automatic send_cell(input tkp_tb_pkg::cell_t c);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 12);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cell_score  <= c.score;
    in_ch.col_index   <= c.col;
    in_ch.row_index   <= c.row;
    in_ch.layer_index <= c.layer;
    in_ch.frame_end   <= c.frame_end;
    do @(posedge clk); while (!in_ch.ready);
    board.note_cell(c);
  endtask

  // Wait out every queued beat, then an idle margin for the report to wind down.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (board.due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access until pready. Only while idle.
  task automatic write_report_count(input logic [tkp_pkg::REPORT_COUNT_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= tkp_pkg::PADDR_W'({tkp_pkg::REG_REPORT_COUNT, 2'b00});
    pwdata  <= tkp_pkg::PDATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.report_count = v;
  endtask

  function automatic tkp_tb_pkg::cell_t mk_cell(logic [tkp_pkg::SCORE_W-1:0] s,
                                                int c, int r, int l, bit last);
    tkp_tb_pkg::cell_t x;
    x.score     = s;
    x.col       = tkp_pkg::COORD_W'(c);
    x.row       = tkp_pkg::COORD_W'(r);
    x.layer     = tkp_pkg::LAYER_W'(l);
    x.frame_end = last;
    return x;
  endfunction

  // Score mix: many zero/negative, many small positives so ties are common,
  // plus full-range values so every bit toggles.
  function automatic logic [tkp_pkg::SCORE_W-1:0] pick_score();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 14) return 32'hFFFF_FFFF;
    if (r < 17) return 32'h8000_0000;
    if (r < 25) return {1'b1, 31'($urandom())};
    if (r < 60) return 32'($urandom_range(1, 6));
    if (r < 63) return 32'h7FFF_FFFF;
    if (r < 65) return 32'h0000_0001;
    return {1'b0, 31'($urandom())} | 32'h1;
  endfunction

  // Random frames until at least n cells went in. Lengths mostly mid-size,
  // some short, some long enough to overflow the 16-entry list.
  task automatic run_random(input int n);
    int sent;
    int len;
    int r;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(0, 99);
      if (r < 15)      len = $urandom_range(1, 3);
      else if (r < 75) len = $urandom_range(4, 20);
      else             len = $urandom_range(17, 40);
      for (int i = 0; i < len; i++)
        send_cell(mk_cell(pick_score(), $urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom_range(0, 15), i == len - 1));
      sent += len;
    end
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [tkp_pkg::REPORT_COUNT_W-1:0] sweep[7];

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, report count at its reset value of 10.
    // Empty frame: most negative score, then zero on the closing cell.
    send_cell(mk_cell(32'h8000_0000, 0, 0, 0, 1'b0));
    send_cell(mk_cell(32'h0000_0000, 63, 63, 15, 1'b1));
    // Single-cell frame with the largest score and extreme indices.
    send_cell(mk_cell(32'h7FFF_FFFF, 63, 63, 15, 1'b1));
    // Equal scores keep arrival order; smallest positive ranks last.
    send_cell(mk_cell(32'h0001_0000, 1, 2, 3, 1'b0));
    send_cell(mk_cell(32'h0000_0001, 4, 5, 6, 1'b0));
    send_cell(mk_cell(32'h0001_0000, 7, 8, 9, 1'b0));
    send_cell(mk_cell(32'hFFFF_FFFF, 10, 11, 12, 1'b1));
    settle();

    // Full list: 16 equal scores fill it, an equal 17th is dropped, and a
    // larger closing cell pushes the newest tail entry out.
    write_report_count(5'd16);
    for (int i = 0; i < 16; i++) send_cell(mk_cell(32'd5, i, 63 - i, i, 1'b0));
    send_cell(mk_cell(32'd5, 42, 42, 7, 1'b0));
    send_cell(mk_cell(32'd6, 33, 44, 5, 1'b1));
    settle();

    // Random phases across the report count: below-range zero, one, full,
    // above range, mid values, and back to the reset value with no idling.
    sweep[0] = 5'd1;
    sweep[1] = 5'd0;
    sweep[2] = 5'd31;
    sweep[3] = tkp_pkg::REPORT_COUNT_W'($urandom_range(2, 15));
    sweep[4] = 5'd16;
    sweep[5] = tkp_pkg::REPORT_COUNT_W'($urandom_range(17, 30));
    sweep[6] = tkp_pkg::REPORT_COUNT_RST;
    for (int p = 0; p < 7; p++) begin
      if (p == 6) quiet = 1'b1;
      write_report_count(sweep[p]);
      run_random(PHASE_CELLS);
    end

    $display("Run covered %0d cells in %0d frames; %0d ranked beats checked,",
             board.cells, board.frames, board.beats);
    $display("report count swept from 0 to 31 with random gaps and stalls.");
    if (board.errors == 0) begin
      $display("tb_top_k_positive_cell_selector_unit: PASS");
    end else begin
      $display("tb_top_k_positive_cell_selector_unit: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #RUN_LIMIT;
    $display("Timeout with %0d result beats still outstanding.", board.due.size());
    $display("tb_top_k_positive_cell_selector_unit: FAIL");
    $finish;
  end

endmodule

>>> top_k_positive_cell_selector_unit.f
src/tkp_pkg.sv
src/tkp_in_if.sv
src/tkp_out_if.sv
src/tkp_datapath.sv
src/tkp_ctrl.sv
src/top_k_positive_cell_selector_unit.sv
verif/tkp_tb_pkg.sv
verif/tb_top_k_positive_cell_selector_unit.sv
